### src/rope_constraint_impulse_defines.svh
// Assertion macros shared by the rope constraint impulse RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ROPE_CONSTRAINT_IMPULSE_DEFINES_SVH
`define ROPE_CONSTRAINT_IMPULSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RCI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rci_pkg.sv
// Shared types and constants for the rope constraint impulse block.
// No dependencies.
package rci_pkg;

    localparam int FRAC_BITS = 16;      // fraction bits of the Q format
    localparam int MAC_A_W   = 35;      // wide multiplier operand
    localparam int MAC_B_W   = 17;      // narrow multiplier operand
    localparam int ACC_W     = 67;      // accumulator
    localparam int MAC_SHIFT = 16;      // weight of the upper operand half
    localparam int QUO_W     = 34;      // quotient width of the shared unit
    localparam int ROOT_W    = 32;
    localparam int NUM_W     = 64;

    typedef enum logic [2:0] {
        CFG_ANCHOR_A_X = 3'd0,
        CFG_ANCHOR_A_Y = 3'd1,
        CFG_ANCHOR_B_X = 3'd2,
        CFG_ANCHOR_B_Y = 3'd3,
        CFG_MAX_LENGTH = 3'd4,
        CFG_STIFFNESS  = 3'd5,
        CFG_TIME_STEP  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        RD_SQRT = 1'b0,
        RD_DIV  = 1'b1
    } t_rd_op;

    typedef enum logic [4:0] {
        S_IDLE, S_WP_M0, S_WP_M1, S_WP_FIN, S_DIFF,
        S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_ROOT_GO, S_ROOT_WAIT, S_LEN,
        S_T_MUL, S_T_FIN, S_J0, S_J1, S_J_FIN,
        S_C0, S_C1, S_DIV_GO, S_DIV_WAIT, S_C_FIN, S_DONE
    } t_state;

    typedef struct packed {
        logic en;
        logic clr;
        logic shift;
    } t_mac_ctl;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_a;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [15:0] cos_b;
        logic signed [15:0] sin_b;
        logic               same_body;
        logic               both_static;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] impulse_x;
        logic signed [31:0] impulse_y;
        logic               apply;
        logic               tight;
        logic signed [31:0] world_a_x;
        logic signed [31:0] world_a_y;
        logic signed [31:0] world_b_x;
        logic signed [31:0] world_b_y;
        logic               saturated;
    } t_out_word;

endpackage

### src/rci_mac.sv
// Shared multiply-accumulate unit: 35x17 signed product, optional 16-bit shift.
// Depends on rci_pkg.
module rci_mac
    import rci_pkg::*;
(
    input  logic                      i_clk,
    input  t_mac_ctl                  i_ctl,
    input  logic signed [MAC_A_W-1:0] i_a,
    input  logic signed [MAC_B_W-1:0] i_b,
    output logic signed [ACC_W-1:0]   o_acc
);

    logic signed [MAC_A_W+MAC_B_W-1:0] w_prod;
    logic signed [ACC_W-1:0]           w_term;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [ACC_W-1:0]           n_acc;

    always_comb begin
        w_prod = i_a * i_b;
        w_term = ACC_W'(w_prod);
        if (i_ctl.shift) begin
            w_term = w_term <<< MAC_SHIFT;
        end
        n_acc = i_ctl.clr ? w_term : r_acc + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### src/rci_rootdiv.sv
// Iterative square root / divide unit sharing one 64-bit subtract-compare.
// Depends on rci_pkg.
module rci_rootdiv
    import rci_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_rd_op            i_op,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_res
);

    localparam int SQRT_ITERS = ROOT_W;
    localparam int CNT_W      = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    t_rd_op           r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_v;
    logic [NUM_W-1:0] r_r;
    logic [NUM_W-1:0] r_bit;
    logic [ROOT_W-1:0] r_rem;
    logic [QUO_W-1:0] r_q;
    logic [ROOT_W-1:0] r_den;

    logic [ROOT_W:0]  w_trial;
    logic [NUM_W-1:0] w_x;
    logic [NUM_W-1:0] w_y;
    logic [NUM_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_q[QUO_W-1]};
        if (r_op == RD_SQRT) begin
            w_x = r_v;
            w_y = r_r + r_bit;
        end else begin
            w_x = NUM_W'(w_trial);
            w_y = NUM_W'(r_den);
        end
        w_diff = {1'b0, w_x} - {1'b0, w_y};
        w_ge   = ~w_diff[NUM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_cnt <= (i_op == RD_SQRT) ? CNT_W'(SQRT_ITERS - 1) : CNT_W'(QUO_W - 1);
            r_v   <= i_num;
            r_r   <= '0;
            r_bit <= NUM_W'(1) << (NUM_W - 2);
            r_rem <= ROOT_W'(i_num[NUM_W-1:QUO_W]);
            r_q   <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_op == RD_SQRT) begin
                if (w_ge) begin
                    r_v <= w_diff[NUM_W-1:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_rem <= w_ge ? w_diff[ROOT_W-1:0] : w_trial[ROOT_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = (r_op == RD_SQRT) ? QUO_W'(r_r[ROOT_W-1:0]) : r_q;

endmodule

### src/rope_constraint_impulse.sv
// Top level of the rope constraint impulse block: sequencer, datapath, I/O words.
// Depends on rci_pkg, rci_mac, rci_rootdiv and rope_constraint_impulse_defines.svh.
//
//   channel   direction  handshake                     word
//   input     in         i_in_valid / o_in_stall       i_in_word  (t_in_word)
//   output    out        o_out_valid / i_out_stall     o_out_word (t_out_word)
//   config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One word at a time; o_in_stall is low only while the sequencer is idle.
// A skipped step goes straight to the output. Any other step forms the world
// points on the shared multiply-accumulate unit and runs the 32-step root in
// rci_rootdiv; a tight cord with a nonzero length adds the two 34-step divides.
// A finished word waits in the output register; the next input word is taken
// meanwhile. Reset (synchronous, active low) clears sequencer, held world
// points, tight flag and registers to their defaults.
module rope_constraint_impulse
    import rci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

`include "rope_constraint_impulse_defines.svh"

    localparam int ROT_HALF  = 8192;
    localparam int ROT_SHIFT = 14;
    localparam int T_HALF    = 32768;
    localparam int T_SHIFT   = 16;
    localparam int J_HALF    = 1 << (FRAC_BITS - 1);

    // Saturate a wide signed value to 32 bits; top bit flags a clamp.
    function automatic logic [32:0] clamp32(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-32:0] hi;
        hi = x[ACC_W-1:31];
        if (&hi || ~|hi) begin
            clamp32 = {1'b0, x[31:0]};
        end else begin
            clamp32 = {1'b1, x[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
    endfunction

    // configuration registers
    logic signed [31:0] r_anc_ax, r_anc_ay, r_anc_bx, r_anc_by;
    logic [30:0]        r_max;
    logic [31:0]        r_stiff;
    logic [15:0]        r_ts;

    // sequencer and held state
    t_state             r_state, n_state;
    logic signed [31:0] r_wp [4];
    logic               r_tight;
    logic               r_ovalid;
    t_out_word          r_oword;

    // datapath registers
    t_in_word           r_in;
    logic [1:0]         r_idx;
    logic signed [32:0] r_dx, r_dy;
    logic [31:0]        r_mx, r_my;
    logic               r_half;
    logic [31:0]        r_root;
    logic [32:0]        r_e;
    logic [33:0]        r_t;
    logic [31:0]        r_j;
    logic signed [31:0] r_ix, r_iy;
    logic               r_apply;
    logic               r_sat;

    // shared units
    t_mac_ctl                  mac_ctl;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      rd_start;
    t_rd_op                    rd_op;
    logic [NUM_W-1:0]          rd_num;
    logic                      rd_busy;
    logic                      rd_done;
    logic [QUO_W-1:0]          rd_res;

    rci_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (r_acc)
    );

    rci_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rd_start),
        .i_op    (rd_op),
        .i_num   (rd_num),
        .i_den   (r_root),
        .o_busy  (rd_busy),
        .o_done  (rd_done),
        .o_res   (rd_res)
    );

    logic               w_skip;
    logic               w_out_free;
    logic signed [31:0] w_pos;
    logic signed [ACC_W-1:0] w_wsum;
    logic [32:0]        w_wp_cl;
    logic signed [32:0] w_dx, w_dy, w_sdx, w_sdy;
    logic [32:0]        w_ux, w_uy;
    logic               w_big;
    logic [32:0]        w_len;
    logic               w_tight;
    logic [ACC_W-1:0]   w_tsum;
    logic [ACC_W-1:0]   w_jsh;
    logic               w_jsat;
    logic [31:0]        w_j;
    logic signed [ACC_W-1:0] w_qx;
    logic [32:0]        w_c_cl;
    logic [31:0]        w_mag;

    // datapath arithmetic around the shared units
    always_comb begin
        w_skip     = i_in_word.same_body | i_in_word.both_static;
        w_out_free = ~r_ovalid | ~i_out_stall;

        case (r_idx)
            2'd0:    w_pos = r_in.pos_a_x;
            2'd1:    w_pos = r_in.pos_a_y;
            2'd2:    w_pos = r_in.pos_b_x;
            default: w_pos = r_in.pos_b_y;
        endcase
        w_wsum  = ((r_acc + ACC_W'(ROT_HALF)) >>> ROT_SHIFT) + ACC_W'(w_pos);
        w_wp_cl = clamp32(w_wsum);

        // halve both differences when either does not fit 31 bits
        w_dx  = {r_wp[2][31], r_wp[2]} - {r_wp[0][31], r_wp[0]};
        w_dy  = {r_wp[3][31], r_wp[3]} - {r_wp[1][31], r_wp[1]};
        w_ux  = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        w_uy  = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
        w_big = w_ux[32] | w_ux[31] | w_uy[32] | w_uy[31];
        w_sdx = w_big ? (w_dx >>> 1) : w_dx;
        w_sdy = w_big ? (w_dy >>> 1) : w_dy;

        w_len   = r_half ? {rd_res[ROOT_W-1:0], 1'b0} : {1'b0, rd_res[ROOT_W-1:0]};
        w_tight = w_len > {2'b00, r_max};

        w_tsum = $unsigned(r_acc) + ACC_W'(T_HALF);
        w_jsh  = ($unsigned(r_acc) + ACC_W'(J_HALF)) >> FRAC_BITS;
        w_jsat = |w_jsh[ACC_W-1:32];
        w_j    = w_jsat ? 32'hFFFF_FFFF : w_jsh[31:0];

        w_mag  = r_idx[0] ? r_my : r_mx;
        w_qx   = ACC_W'(rd_res);
        w_c_cl = clamp32((r_idx[0] ? r_dy[32] : r_dx[32]) ? -w_qx : w_qx);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = w_skip ? S_DONE : S_WP_M0;
            S_WP_M0:     n_state = S_WP_M1;
            S_WP_M1:     n_state = S_WP_FIN;
            S_WP_FIN:    n_state = (r_idx == 2'd3) ? S_DIFF : S_WP_M0;
            S_DIFF:      n_state = S_SQ0;
            S_SQ0:       n_state = S_SQ1;
            S_SQ1:       n_state = S_SQ2;
            S_SQ2:       n_state = S_SQ3;
            S_SQ3:       n_state = S_ROOT_GO;
            S_ROOT_GO:   n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: if (rd_done) n_state = S_LEN;
            S_LEN:       n_state = w_tight ? S_T_MUL : S_DONE;
            S_T_MUL:     n_state = S_T_FIN;
            S_T_FIN:     n_state = S_J0;
            S_J0:        n_state = S_J1;
            S_J1:        n_state = S_J_FIN;
            S_J_FIN:     n_state = (r_root == '0) ? S_DONE : S_C0;
            S_C0:        n_state = S_C1;
            S_C1:        n_state = S_DIV_GO;
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (rd_done) n_state = S_C_FIN;
            S_C_FIN:     n_state = r_idx[0] ? S_DONE : S_C0;
            S_DONE:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: unit controls and operand steering
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        mac_ctl    = '{en: 1'b0, clr: 1'b0, shift: 1'b0};
        mac_a      = '0;
        mac_b      = '0;
        rd_start   = 1'b0;
        rd_op      = RD_SQRT;
        rd_num     = r_acc[NUM_W-1:0];
        case (r_state)
            S_WP_M0: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
                mac_a   = MAC_A_W'(r_idx[1] ? r_anc_bx : r_anc_ax);
                case (r_idx)
                    2'd0:    mac_b = MAC_B_W'(r_in.cos_a);
                    2'd1:    mac_b = MAC_B_W'(r_in.sin_a);
                    2'd2:    mac_b = MAC_B_W'(r_in.cos_b);
                    default: mac_b = MAC_B_W'(r_in.sin_b);
                endcase
            end
            S_WP_M1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
                mac_a   = MAC_A_W'(r_idx[1] ? r_anc_by : r_anc_ay);
                case (r_idx)
                    2'd0:    mac_b = -MAC_B_W'(r_in.sin_a);
                    2'd1:    mac_b = MAC_B_W'(r_in.cos_a);
                    2'd2:    mac_b = -MAC_B_W'(r_in.sin_b);
                    default: mac_b = MAC_B_W'(r_in.cos_b);
                endcase
            end
            S_SQ0: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
                mac_a   = MAC_A_W'(r_mx);
                mac_b   = MAC_B_W'(r_mx[15:0]);
            end
            S_SQ1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
                mac_a   = MAC_A_W'(r_mx);
                mac_b   = MAC_B_W'(r_mx[31:16]);
            end
            S_SQ2: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
                mac_a   = MAC_A_W'(r_my);
                mac_b   = MAC_B_W'(r_my[15:0]);
            end
            S_SQ3: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
                mac_a   = MAC_A_W'(r_my);
                mac_b   = MAC_B_W'(r_my[31:16]);
            end
            S_ROOT_GO: begin
                rd_start = 1'b1;
            end
            S_T_MUL: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
                mac_a   = MAC_A_W'(r_e);
                mac_b   = MAC_B_W'(r_ts);
            end
            S_J0: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
                mac_a   = MAC_A_W'(r_t);
                mac_b   = MAC_B_W'(r_stiff[15:0]);
            end
            S_J1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
                mac_a   = MAC_A_W'(r_t);
                mac_b   = MAC_B_W'(r_stiff[31:16]);
            end
            S_C0: begin
                mac_ctl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
                mac_a   = MAC_A_W'(w_mag);
                mac_b   = MAC_B_W'(r_j[15:0]);
            end
            S_C1: begin
                mac_ctl = '{en: 1'b1, clr: 1'b0, shift: 1'b1};
                mac_a   = MAC_A_W'(w_mag);
                mac_b   = MAC_B_W'(r_j[31:16]);
            end
            S_DIV_GO: begin
                // round half up: add half the divisor before dividing
                rd_start = 1'b1;
                rd_op    = RD_DIV;
                rd_num   = r_acc[NUM_W-1:0] + NUM_W'(r_root[31:1]);
            end
            default: begin
            end
        endcase
    end

    // control state, held results and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_tight  <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_wp[k] <= '0;
            end
            r_anc_ax <= '0;
            r_anc_ay <= '0;
            r_anc_bx <= '0;
            r_anc_by <= '0;
            r_max    <= 31'd65536;
            r_stiff  <= 32'd65536;
            r_ts     <= 16'd1092;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_WP_FIN) begin
                r_wp[r_idx] <= w_wp_cl[31:0];
            end
            if (r_state == S_LEN) begin
                r_tight <= w_tight;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ANCHOR_A_X: r_anc_ax <= i_cfg_data;
                    CFG_ANCHOR_A_Y: r_anc_ay <= i_cfg_data;
                    CFG_ANCHOR_B_X: r_anc_bx <= i_cfg_data;
                    CFG_ANCHOR_B_Y: r_anc_by <= i_cfg_data;
                    CFG_MAX_LENGTH: r_max    <= i_cfg_data[30:0];
                    CFG_STIFFNESS:  r_stiff  <= i_cfg_data;
                    CFG_TIME_STEP:  r_ts     <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // latch the word and clear the per-step results
                r_in    <= i_in_word;
                r_idx   <= '0;
                r_ix    <= '0;
                r_iy    <= '0;
                r_apply <= 1'b0;
                r_sat   <= 1'b0;
            end
            S_WP_FIN: begin
                r_idx <= r_idx + 1'b1;
                r_sat <= r_sat | w_wp_cl[32];
            end
            S_DIFF: begin
                r_dx   <= w_sdx;
                r_dy   <= w_sdy;
                r_mx   <= w_sdx[32] ? 32'(-w_sdx) : w_sdx[31:0];
                r_my   <= w_sdy[32] ? 32'(-w_sdy) : w_sdy[31:0];
                r_half <= w_big;
            end
            S_LEN: begin
                r_root  <= rd_res[ROOT_W-1:0];
                r_e     <= w_len - {2'b00, r_max};
                r_apply <= w_tight;
            end
            S_T_FIN: begin
                r_t <= w_tsum[T_SHIFT+33:T_SHIFT];
            end
            S_J_FIN: begin
                r_j   <= w_j;
                r_idx <= '0;
                r_sat <= r_sat | w_jsat | ((r_root == '0) & w_j[31]);
                if (r_root == '0) begin
                    // zero direction: push along +x
                    r_ix <= w_j[31] ? 32'h7FFF_FFFF : w_j;
                end
            end
            S_C_FIN: begin
                r_idx <= r_idx + 1'b1;
                r_sat <= r_sat | w_c_cl[32];
                if (r_idx[0]) begin
                    r_iy <= w_c_cl[31:0];
                end else begin
                    r_ix <= w_c_cl[31:0];
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_oword <= '{impulse_x: r_ix, impulse_y: r_iy, apply: r_apply,
                                 tight: r_tight, world_a_x: r_wp[0], world_a_y: r_wp[1],
                                 world_b_x: r_wp[2], world_b_y: r_wp[3], saturated: r_sat};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    `RCI_ASSERT_NEXT(a_run_starts, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid && !w_skip, r_state == S_WP_M0, "active word did not start the world point pass")
    `RCI_ASSERT_NOW(a_apply_tight, i_clk, i_rst_n, r_state == S_DONE && r_apply, r_tight, "impulse applied on a slack cord")
    `RCI_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV_GO, r_root != '0, "divide started with zero length")
    `RCI_ASSERT_NOW(a_unit_free, i_clk, i_rst_n, rd_start, !rd_busy, "root/divide unit restarted while busy")

endmodule

### dv/rci_checker.sv
// Checker for the rope constraint impulse block: predicts each output word
// from accepted input words and the register writes, compares field by field.
// Depends on rci_pkg for the word types and register indexes.
module rci_checker
    import rci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_tight_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] anc_ax, anc_ay, anc_bx, anc_by;
    logic [30:0] max_len;
    logic [31:0] stiff;
    logic [15:0] dt;
    logic tight_q;
    logic signed [31:0] held_w [4];
    t_out_word impulse_q [$];

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint sat32(longint x, ref bit sat);
        if (x > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint along_dir(longint unsigned j, longint d,
                                         longint unsigned len, ref bit sat);
        longint unsigned mag, q;
        mag = d < 0 ? -d : d;
        q = (j * mag + len / 2) / len;
        return sat32(d < 0 ? -longint'(q) : longint'(q), sat);
    endfunction

    function automatic t_out_word solve_rope(t_in_word w);
        t_out_word r;
        bit sat;
        longint wp [4];
        longint dx, dy, ix, iy;
        longint unsigned ux, uy, root, len, e, t, j;
        sat = 0;
        ix = 0;
        iy = 0;
        r = '0;
        if (!w.same_body && !w.both_static) begin
            wp[0] = sat32(longint'(w.pos_a_x) + floor_shift(longint'(w.cos_a) * anc_ax
                    - longint'(w.sin_a) * anc_ay + 8192, 14), sat);
            wp[1] = sat32(longint'(w.pos_a_y) + floor_shift(longint'(w.sin_a) * anc_ax
                    + longint'(w.cos_a) * anc_ay + 8192, 14), sat);
            wp[2] = sat32(longint'(w.pos_b_x) + floor_shift(longint'(w.cos_b) * anc_bx
                    - longint'(w.sin_b) * anc_by + 8192, 14), sat);
            wp[3] = sat32(longint'(w.pos_b_y) + floor_shift(longint'(w.sin_b) * anc_bx
                    + longint'(w.cos_b) * anc_by + 8192, 14), sat);
            for (int i = 0; i < 4; i++) held_w[i] = wp[i];
            dx = wp[2] - wp[0];
            dy = wp[3] - wp[1];
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            if (ux >= 64'd2147483648 || uy >= 64'd2147483648) begin
                dx = dx >>> 1;
                dy = dy >>> 1;
                ux = dx < 0 ? -dx : dx;
                uy = dy < 0 ? -dy : dy;
                root = int_sqrt(ux * ux + uy * uy);
                len = root * 2;
            end else begin
                root = int_sqrt(ux * ux + uy * uy);
                len = root;
            end
            tight_q = len > max_len;
            if (tight_q) begin
                e = len - max_len;
                t = (e * dt + 32768) >> 16;
                if (stiff != 0 && t > ((64'd1 << (32 + FRAC_BITS)) - 1) / stiff) begin
                    j = 64'hFFFF_FFFF;
                    sat = 1;
                end else begin
                    j = (t * stiff + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    if (j > 64'hFFFF_FFFF) begin
                        j = 64'hFFFF_FFFF;
                        sat = 1;
                    end
                end
                if (root == 0) begin
                    ix = sat32(longint'(j), sat);
                end else begin
                    ix = along_dir(j, dx, root, sat);
                    iy = along_dir(j, dy, root, sat);
                end
                r.apply = 1;
            end
        end
        r.impulse_x = ix[31:0];
        r.impulse_y = iy[31:0];
        r.tight = tight_q;
        r.world_a_x = held_w[0];
        r.world_a_y = held_w[1];
        r.world_b_x = held_w[2];
        r.world_b_y = held_w[3];
        r.saturated = sat;
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            anc_ax = 0; anc_ay = 0; anc_bx = 0; anc_by = 0;
            max_len = 65536;
            stiff = 65536;
            dt = 1092;
            tight_q = 0;
            for (int i = 0; i < 4; i++) held_w[i] = 0;
            impulse_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ANCHOR_A_X: anc_ax = i_cfg_data;
                    CFG_ANCHOR_A_Y: anc_ay = i_cfg_data;
                    CFG_ANCHOR_B_X: anc_bx = i_cfg_data;
                    CFG_ANCHOR_B_Y: anc_by = i_cfg_data;
                    CFG_MAX_LENGTH: max_len = i_cfg_data[30:0];
                    CFG_STIFFNESS:  stiff = i_cfg_data;
                    CFG_TIME_STEP:  dt = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (impulse_q.size() == 0) begin
                    $error("output word with no prediction pending");
                    o_errors++;
                end else begin
                    want = impulse_q.pop_front();
                    if (want.tight) o_tight_seen++;
                    check_field("impulse_x", want.impulse_x, i_out_word.impulse_x);
                    check_field("impulse_y", want.impulse_y, i_out_word.impulse_y);
                    check_field("apply", want.apply, i_out_word.apply);
                    check_field("tight", want.tight, i_out_word.tight);
                    check_field("world_a_x", want.world_a_x, i_out_word.world_a_x);
                    check_field("world_a_y", want.world_a_y, i_out_word.world_a_y);
                    check_field("world_b_x", want.world_b_x, i_out_word.world_b_x);
                    check_field("world_b_y", want.world_b_y, i_out_word.world_b_y);
                    check_field("saturated", want.saturated, i_out_word.saturated);
                end
            end
            if (i_in_valid && !i_in_stall) impulse_q.push_back(solve_rope(i_in_word));
        end
        o_pending = impulse_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_tight_seen = 0;
    end
endmodule

### dv/tb_rope_constraint_impulse.sv
// Testbench top for the rope constraint impulse block: clock, reset, register
// phases, directed and random pose words, stalls and the verdict.
// Depends on rci_pkg, rope_constraint_impulse and rci_checker.
module tb_rope_constraint_impulse
    import rci_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;   // cycles with no handshake at all

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          errors, pending, results, tight_seen;
    int          send_idle_pct, recv_stall_pct;
    int          idle_cycles;
    int          sent;
    bit          hold_off;
    bit          timed_out;

    rope_constraint_impulse DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    rci_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_tight_seen(tight_seen)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Receiver: stall at the phase's rate, or hold off entirely while the
    // long back-pressure stretch runs.
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            timed_out = 1;
            $display("tb_rope_constraint_impulse: done, errors");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_trig();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic t_in_word rand_pose();
        t_in_word w;
        w.pos_a_x = rand_q16();
        w.pos_a_y = rand_q16();
        w.pos_b_x = rand_q16();
        w.pos_b_y = rand_q16();
        w.cos_a = rand_trig();
        w.sin_a = rand_trig();
        w.cos_b = rand_trig();
        w.sin_b = rand_trig();
        // mostly active steps; skipped ones now and then
        w.same_body = ($urandom_range(9) == 0);
        w.both_static = ($urandom_range(9) == 0);
        return w;
    endfunction

    // Offer one word after a random gap; hold it until taken. Valid stays
    // high after the handshake until the next call or drain drops it.
    task automatic send_pose(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // Drive one register write; the caller drops the write enable.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Drain: drop valid, wait until every prediction is matched, then give
    // the block time to settle before any register moves.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_rope(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                            logic [31:0] by, logic [31:0] maxl, logic [31:0] k,
                            logic [31:0] h);
        write_reg(CFG_ANCHOR_A_X, ax);
        write_reg(CFG_ANCHOR_A_Y, ay);
        write_reg(CFG_ANCHOR_B_X, bx);
        write_reg(CFG_ANCHOR_B_Y, by);
        write_reg(CFG_MAX_LENGTH, maxl);
        write_reg(CFG_STIFFNESS, k);
        write_reg(CFG_TIME_STEP, h);
        cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_word w;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        out_stall = 1'b0;
        hold_off = 0;
        idle_cycles = 0;
        sent = 0;
        timed_out = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers first, then edge poses.
        w = '0;
        send_pose(w);                              // coincident points, slack
        w.pos_b_x = 32'sd5 << 16;
        send_pose(w);                              // tight along +x
        w.pos_b_x = -(32'sd5 << 16);
        w.pos_b_y = 32'sd3 << 16;
        send_pose(w);                              // tight, mixed signs
        w.same_body = 1;
        send_pose(w);                              // skipped: hold world points
        w.same_body = 0;
        w.both_static = 1;
        send_pose(w);                              // skipped
        w.same_body = 1;
        send_pose(w);
        w = '0;
        w.pos_a_x = 32'sh8000_0000;
        w.pos_a_y = 32'sh8000_0000;
        w.pos_b_x = 32'sh7FFF_FFFF;
        w.pos_b_y = 32'sh7FFF_FFFF;
        send_pose(w);                              // huge span, halved length
        drain();

        // Extreme anchors and gains: world-point clamp and impulse clamp.
        set_rope(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0, 32'hFFFF_FFFF, 32'hFFFF);
        w.cos_a = 16'sd16384;  w.sin_a = -16'sd16384;
        w.cos_b = -16'sd16384; w.sin_b = 16'sd16384;
        send_pose(w);
        w.pos_a_x = 32'h7FFF_FFFF;
        w.pos_b_x = 32'h8000_0000;
        w.pos_a_y = 0;
        w.pos_b_y = 0;
        send_pose(w);
        w = '1;
        w.same_body = 0;
        w.both_static = 0;
        send_pose(w);
        drain();
        set_rope(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_pose(w);                              // never tight
        w = '0;
        w.pos_b_y = 32'sh4000_0000;
        send_pose(w);
        drain();

        // Random phases: each one with its own rope and idling mix.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            set_rope(rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     ph == 4 ? 32'd65536 : $urandom_range(16 << 16),
                     ph == 0 ? 32'hFFFF_FFFF : $urandom_range(32'h0010_0000),
                     ph == 3 ? 32'hFFFF : $urandom_range(16'hFFFF));
            if (ph == 4) begin
                // Long back-pressure stretch while the sender keeps offering.
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 345; n++) send_pose(rand_pose());
            drain();
        end

        $display("covered %0d pose words, %0d results checked, %0d with a tight cord",
                 sent, results, tight_seen);
        if (errors == 0) begin
            $display("tb_rope_constraint_impulse: done, clean");
        end else begin
            $display("tb_rope_constraint_impulse: done, errors");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+src
src/rci_pkg.sv
src/rci_mac.sv
src/rci_rootdiv.sv
src/rope_constraint_impulse.sv
dv/rci_checker.sv
dv/tb_rope_constraint_impulse.sv
